@@ rtl/kbt_pkg.sv @@
// Shared types and codes for the key binding table.
package kbt_pkg;

   // One table entry: key code and bound function id.
   typedef struct packed {
      logic [15:0] key;
      logic [7:0]  func;
   } entry_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctl_type;

   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_BIND   = 2'd1;
   localparam logic [1:0] KIND_UNBIND = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FUNC = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_UNBOUND = 2'd3;

   localparam logic [7:0] FUNC_NONE   = 8'd0;
   localparam logic [7:0] FUNC_META   = 8'd1;
   localparam logic [7:0] FUNC_CTLX   = 8'd2;
   localparam logic [7:0] FUNC_REPEAT = 8'd3;
   localparam logic [7:0] FUNC_ABORT  = 8'd4;

endpackage

@@ rtl/kbt_if.sv @@
// Request and response channel interfaces for the key binding table.
interface kbt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] key_code;
   logic [7:0]  func_id;

   modport source (output valid, kind, key_code, func_id, input ready);
   modport sink   (input valid, kind, key_code, func_id, output ready);
endinterface

interface kbt_rsp_if #(parameter int COUNT_W = 9);
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [7:0]         bound_func;
   logic [15:0]        meta_key;
   logic [15:0]        ctlx_key;
   logic [15:0]        repeat_key;
   logic [15:0]        abort_key;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, status, bound_func, meta_key, ctlx_key, repeat_key,
                   abort_key, entry_count, input ready);
   modport sink   (input valid, status, bound_func, meta_key, ctlx_key, repeat_key,
                   abort_key, entry_count, output ready);
endinterface

@@ rtl/kbt_cell.sv @@
// One storage cell of the entry chain.
module kbt_cell #(
   parameter int POS_W = 9,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  kbt_pkg::cell_ctl_type ctl,
   input  logic [POS_W-1:0]      wr_pos,
   input  kbt_pkg::entry_type    wr_data,
   input  kbt_pkg::entry_type    nbr_data,
   output kbt_pkg::entry_type    data
);

   kbt_pkg::entry_type data_ff;
   kbt_pkg::entry_type data_in;
   logic               hit;

   // Write targets this cell when the broadcast position matches
   assign hit = ctl.write && (wr_pos == POS_W'(INDEX));

   always_comb begin
      data_in = data_ff;
      if (hit) begin
         data_in = wr_data;
      end else if (ctl.shift) begin
         data_in = nbr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ rtl/key_binding_table_top.sv @@
// Key binding table: chain of entry cells and the sequencer that scans it.
//
// Usage: one request on req_bus (kind, key_code, func_id) gives one response on
// rsp_bus (status, bound_func, the four prefix keys, entry_count).
// Every lookup, bind and unbind streams the stored entries through the head
// of the cell chain, one entry per cycle: entries are examined, modified or
// dropped, and kept ones are written back behind the unprocessed ones, so
// the table stays packed. A bind with id zero or an unused kind skips the
// scan. The scan length sets the rate; the block takes one request at a
// time and req_bus.ready is high only while idle.
// The response sits in an output register; a finished result waits there
// while the next request is accepted and scanned. If the receiver stalls
// with a response still held, the block keeps the next result until the
// register frees up.
// Reset (synchronous) empties the table, clears the prefix keys and drops
// any pending response. Entry order may differ from insertion order; keys
// are unique so lookups are unaffected.
module key_binding_table_top #(
   parameter int TABLE_DEPTH = 256
) (
   input logic       clock,
   input logic       reset,
   kbt_req_if.sink   req_bus,
   kbt_rsp_if.source rsp_bus
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] key_ff, key_in;
   logic [7:0]  func_ff, func_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic        found_ff, found_in;
   logic [7:0]  bound_ff, bound_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] meta_ff, meta_in;
   logic [15:0] ctlx_ff, ctlx_in;
   logic [15:0] repeat_ff, repeat_in;
   logic [15:0] abort_ff, abort_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_bound_ff, rsp_bound_in;
   logic [15:0] rsp_meta_ff, rsp_meta_in;
   logic [15:0] rsp_ctlx_ff, rsp_ctlx_in;
   logic [15:0] rsp_repeat_ff, rsp_repeat_in;
   logic [15:0] rsp_abort_ff, rsp_abort_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;

   kbt_pkg::entry_type    cell_q [TABLE_DEPTH];
   kbt_pkg::entry_type    head;
   kbt_pkg::entry_type    wr_data;
   kbt_pkg::cell_ctl_type ctl;
   logic [CW-1:0]         wr_pos;
   logic                  scanning;
   logic                  is_prefix;
   logic                  drop;
   logic                  key_hit;
   logic                  append;

   // Cell chain: each cell passes its entry toward the head
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      kbt_cell #(.POS_W(CW), .INDEX(g)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .wr_pos   (wr_pos),
         .wr_data  (wr_data),
         .nbr_data (cell_q[(g + 1) % TABLE_DEPTH]),
         .data     (cell_q[g])
      );
   end

   assign head      = cell_q[0];
   assign scanning  = (state_ff == ST_SCAN) && (rem_ff != '0);
   assign is_prefix = (func_ff != kbt_pkg::FUNC_NONE) && (func_ff <= kbt_pkg::FUNC_ABORT);
   assign key_hit   = (head.key == key_ff);

   // Per-entry decision at the chain head
   always_comb begin
      drop    = 1'b0;
      wr_data = head;
      case (kind_ff)
         kbt_pkg::KIND_UNBIND: begin
            drop = key_hit;
         end
         kbt_pkg::KIND_BIND: begin
            if (is_prefix && (head.func == func_ff)) begin
               drop = 1'b1;
            end else if (key_hit) begin
               wr_data.func = func_ff;
            end
         end
         default: begin
            drop = 1'b0;
         end
      endcase
      if (state_ff == ST_FINISH) begin
         wr_data.key  = key_ff;
         wr_data.func = func_ff;
      end
   end

   assign append = (state_ff == ST_FINISH) && (kind_ff == kbt_pkg::KIND_BIND) && !found_ff
                   && (done_ff < CW'(TABLE_DEPTH));

   assign ctl.shift = scanning;
   assign ctl.write = (scanning && !drop) || append;
   assign wr_pos    = (state_ff == ST_FINISH) ? done_ff : CW'(rem_ff - 1'b1 + done_ff);

   assign req_bus.ready = (state_ff == ST_IDLE);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      key_in    = key_ff;
      func_in   = func_ff;
      rem_in    = rem_ff;
      done_in   = done_ff;
      count_in  = count_ff;
      found_in  = found_ff;
      bound_in  = bound_ff;
      status_in = status_ff;
      meta_in   = meta_ff;
      ctlx_in   = ctlx_ff;
      repeat_in = repeat_ff;
      abort_in  = abort_ff;

      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bound_in  = rsp_bound_ff;
      rsp_meta_in   = rsp_meta_ff;
      rsp_ctlx_in   = rsp_ctlx_ff;
      rsp_repeat_in = rsp_repeat_ff;
      rsp_abort_in  = rsp_abort_ff;
      rsp_count_in  = rsp_count_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               kind_in   = req_bus.kind;
               key_in    = req_bus.key_code;
               func_in   = req_bus.func_id;
               rem_in    = count_ff;
               done_in   = '0;
               found_in  = 1'b0;
               bound_in  = kbt_pkg::FUNC_NONE;
               status_in = kbt_pkg::STATUS_OK;
               if ((req_bus.kind == kbt_pkg::KIND_BIND) &&
                   (req_bus.func_id == kbt_pkg::FUNC_NONE)) begin
                  status_in = kbt_pkg::STATUS_NO_FUNC;
                  state_in  = ST_DONE;
               end else if ((req_bus.kind == kbt_pkg::KIND_LOOKUP) ||
                            (req_bus.kind == kbt_pkg::KIND_BIND) ||
                            (req_bus.kind == kbt_pkg::KIND_UNBIND)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (rem_ff != '0) begin
               rem_in  = rem_ff - 1'b1;
               done_in = drop ? done_ff : CW'(done_ff + 1'b1);
               if (key_hit) begin
                  if (kind_ff == kbt_pkg::KIND_LOOKUP) begin
                     bound_in = head.func;
                  end else if (kind_ff == kbt_pkg::KIND_UNBIND) begin
                     found_in = 1'b1;
                  end else if (!drop) begin
                     // Overwrite clears the prefix the entry held
                     found_in = 1'b1;
                     case (head.func)
                        kbt_pkg::FUNC_META:   meta_in   = '0;
                        kbt_pkg::FUNC_CTLX:   ctlx_in   = '0;
                        kbt_pkg::FUNC_REPEAT: repeat_in = '0;
                        kbt_pkg::FUNC_ABORT:  abort_in  = '0;
                        default:              meta_in   = meta_ff;
                     endcase
                  end
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            count_in = done_ff;
            if ((kind_ff == kbt_pkg::KIND_UNBIND) && !found_ff) begin
               status_in = kbt_pkg::STATUS_UNBOUND;
            end
            if (kind_ff == kbt_pkg::KIND_BIND) begin
               case (func_ff)
                  kbt_pkg::FUNC_META:   meta_in   = key_ff;
                  kbt_pkg::FUNC_CTLX:   ctlx_in   = key_ff;
                  kbt_pkg::FUNC_REPEAT: repeat_in = key_ff;
                  kbt_pkg::FUNC_ABORT:  abort_in  = key_ff;
                  default:              meta_in   = meta_ff;
               endcase
               if (!found_ff) begin
                  if (append) begin
                     count_in = CW'(done_ff + 1'b1);
                  end else begin
                     status_in = kbt_pkg::STATUS_FULL;
                  end
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hand over to the output register once it is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_bound_in  = bound_ff;
               rsp_meta_in   = meta_ff;
               rsp_ctlx_in   = ctlx_ff;
               rsp_repeat_in = repeat_ff;
               rsp_abort_in  = abort_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         meta_ff      <= '0;
         ctlx_ff      <= '0;
         repeat_ff    <= '0;
         abort_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         meta_ff      <= meta_in;
         ctlx_ff      <= ctlx_in;
         repeat_ff    <= repeat_in;
         abort_ff     <= abort_in;
      end
   end

   // Operation and response payload
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      func_ff       <= func_in;
      rem_ff        <= rem_in;
      done_ff       <= done_in;
      found_ff      <= found_in;
      bound_ff      <= bound_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bound_ff  <= rsp_bound_in;
      rsp_meta_ff   <= rsp_meta_in;
      rsp_ctlx_ff   <= rsp_ctlx_in;
      rsp_repeat_ff <= rsp_repeat_in;
      rsp_abort_ff  <= rsp_abort_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.bound_func  = rsp_bound_ff;
   assign rsp_bus.meta_key    = rsp_meta_ff;
   assign rsp_bus.ctlx_key    = rsp_ctlx_ff;
   assign rsp_bus.repeat_key  = rsp_repeat_ff;
   assign rsp_bus.abort_key   = rsp_abort_ff;
   assign rsp_bus.entry_count = rsp_count_ff;

endmodule

@@ rtl/kbt_checker.sv @@
// Port-level checks for the key binding table, bound to the top level.
module kbt_checker #(
   parameter int TABLE_DEPTH = 256,
   parameter int CW          = 9
) (
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic [1:0]    rsp_status,
   input logic [7:0]    rsp_bound_func,
   input logic [CW-1:0] rsp_entry_count
);

   // A pending response is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Reset clears any pending response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Table never reports more entries than it holds
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CW'(TABLE_DEPTH)))
      else $error("entry count beyond capacity");

   // A bound function is only reported with an ok status
   a_bound_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_bound_func != kbt_pkg::FUNC_NONE)
         |-> (rsp_status == kbt_pkg::STATUS_OK))
      else $error("bound function with error status");

endmodule

bind key_binding_table_top kbt_checker #(
   .TABLE_DEPTH (TABLE_DEPTH),
   .CW          (CW)
) u_kbt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_bound_func  (rsp_bus.bound_func),
   .rsp_entry_count (rsp_bus.entry_count)
);
